// ===== hdl/abe_pkg.sv =====
// Shared types and constants of the allocation bitmap engine.
// Request codes, controller states and the command/status bundles.
// No dependencies.
`default_nettype none

package abe_pkg;

    localparam int WORD_BITS = 64;
    localparam int OFF_W     = 6;
    localparam int POS_W     = 12;
    localparam int NB_W      = 13;
    localparam int REQ_W     = 3;

    localparam logic [NB_W-1:0] NUM_BITS_RESET = 13'd4096;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR_ALL = 3'd0,
        REQ_SET       = 3'd1,
        REQ_CLEAR     = 3'd2,
        REQ_TEST      = 3'd3,
        REQ_ALLOC     = 3'd4,
        REQ_FIND_FREE = 3'd5,
        REQ_FIND_SET  = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic bit_mod;
        logic scan;
        logic alloc_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        req_t req_in;
        logic in_oor;
        req_t req;
        logic clr_last;
        logic scan_done;
        logic scan_found;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/abe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module abe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/abe_ctrl.sv =====
// Controller state machine of the allocation bitmap engine.
// Depends on abe_pkg; drives commands into abe_dp and reads its status.
`default_nettype none

module abe_ctrl
    import abe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (sts.req_in) inside
                        REQ_CLEAR_ALL:
                            state_next = ST_CLEAR;
                        REQ_SET, REQ_CLEAR, REQ_TEST:
                            state_next = sts.in_oor ? ST_DONE : ST_READ;
                        REQ_ALLOC, REQ_FIND_FREE, REQ_FIND_SET:
                            state_next = ST_SCAN;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
                state_next = ST_MODIFY;
            ST_MODIFY:
                state_next = ST_DONE;
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = (sts.scan_found && sts.req == REQ_ALLOC) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
                cmd.clr_step = 1'b1;
            ST_IDLE:
                cmd.load = accept;
            ST_READ:
                cmd = '0;
            ST_MODIFY:
                cmd.bit_mod = 1'b1;
            ST_SCAN:
                cmd.scan = 1'b1;
            ST_WRITE:
                cmd.alloc_wr = 1'b1;
            ST_DONE:
                cmd.out_load = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/abe_dp.sv =====
// Datapath of the allocation bitmap engine: bitmap RAM, scan pipeline,
// limit register and output word register. Depends on abe_pkg and abe_ram.
`default_nettype none

module abe_dp
    import abe_pkg::*;
#(
    parameter int MAX_BITS = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [REQ_W-1:0]  req_in,
    input  wire logic [POS_W-1:0]  pos_in,
    input  wire logic              cfg_wen,
    input  wire logic [NB_W-1:0]   cfg_wdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,
    input  wire cmd_t              cmd,
    output sts_t                   sts
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LW        = ($clog2(MAX_BITS + 1) > NB_W) ? $clog2(MAX_BITS + 1) : NB_W;
    localparam int WCW       = LW - OFF_W + 1;
    localparam int IW        = WCW + OFF_W;

    function automatic logic [OFF_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = OFF_W'(i);
            end
        end
        return r;
    endfunction

    logic [NB_W-1:0]      num_bits_reg;
    logic [LW-1:0]        lim_now;
    logic                 in_oor;
    req_t                 req_in_t;

    req_t                 req_reg,   req_next;
    logic [POS_W-1:0]     pos_reg,   pos_next;
    logic [LW-1:0]        lim_reg,   lim_next;
    logic [WCW-1:0]       rd_w_reg,  rd_w_next;
    logic [WCW-1:0]       chk_w_reg, chk_w_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [OFF_W-1:0]     off_reg,   off_next;
    logic                 hit_reg,   hit_next;
    logic [POS_W-1:0]     found_reg, found_next;
    logic                 rerr_reg,  rerr_next;
    logic [WORD_BITS-1:0] wdata_reg, wdata_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 o_hit_reg,  o_hit_next;
    logic [POS_W-1:0]     o_found_reg, o_found_next;
    logic                 o_rerr_reg, o_rerr_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 want;
    logic                 rd_ok;
    logic [WORD_BITS-1:0] target;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] low_bit;
    logic [IW-1:0]        idx;
    logic                 in_lim;
    logic                 word_hit;
    logic                 scan_done;
    logic [WORD_BITS-1:0] bit_mask;

    assign req_in_t = req_t'(req_in);
    assign lim_now  = (LW'(num_bits_reg) > LW'(MAX_BITS)) ? LW'(MAX_BITS) : LW'(num_bits_reg);
    assign in_oor   = LW'(pos_in) >= lim_now;

    assign want     = (req_reg == REQ_FIND_SET);
    assign rd_ok    = (rd_w_reg < WCW'(NUM_WORDS)) && ({rd_w_reg, {OFF_W{1'b0}}} < IW'(lim_reg));
    assign target   = want ? ram_rdata : ~ram_rdata;
    assign masked   = target & ({WORD_BITS{1'b1}} << off_reg);
    assign low_bit  = masked & (~masked + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign idx      = {chk_w_reg, first_set(masked)};
    assign in_lim   = idx < IW'(lim_reg);
    assign word_hit = chk_vld_reg && (masked != '0);
    assign scan_done = word_hit || (!chk_vld_reg && !rd_ok);
    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_reg[OFF_W-1:0];

    assign sts.req_in     = req_in_t;
    assign sts.in_oor     = in_oor;
    assign sts.req        = req_reg;
    assign sts.clr_last   = (rd_w_reg == WCW'(NUM_WORDS - 1));
    assign sts.scan_done  = scan_done;
    assign sts.scan_found = word_hit && in_lim;
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        req_next      = req_reg;
        pos_next      = pos_reg;
        lim_next      = lim_reg;
        rd_w_next     = rd_w_reg;
        chk_w_next    = chk_w_reg;
        chk_vld_next  = chk_vld_reg;
        off_next      = off_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        rerr_next     = rerr_reg;
        wdata_next    = wdata_reg;
        m_tvalid_next = m_tvalid_reg;
        o_hit_next    = o_hit_reg;
        o_found_next  = o_found_reg;
        o_rerr_next   = o_rerr_reg;
        ram_we        = 1'b0;
        ram_waddr     = rd_w_reg[AW-1:0];
        ram_wdata     = '0;

        if (cmd.load)
        begin
            req_next     = req_in_t;
            pos_next     = pos_in;
            lim_next     = lim_now;
            chk_vld_next = 1'b0;
            hit_next     = 1'b1;
            found_next   = '0;
            rerr_next    = 1'b0;
            case (req_in_t) inside
                REQ_SET, REQ_CLEAR, REQ_TEST:
                begin
                    if (in_oor)
                    begin
                        rerr_next = 1'b1;
                        hit_next  = (req_in_t != REQ_TEST);
                    end
                end
                default:
                    rerr_next = 1'b0;
            endcase
            case (req_in_t) inside
                REQ_CLEAR_ALL, REQ_ALLOC:
                    rd_w_next = '0;
                default:
                    rd_w_next = WCW'(pos_in[POS_W-1:OFF_W]);
            endcase
            case (req_in_t) inside
                REQ_FIND_FREE, REQ_FIND_SET:
                    off_next = pos_in[OFF_W-1:0];
                default:
                    off_next = '0;
            endcase
        end

        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            rd_w_next = rd_w_reg + 1'b1;
        end

        if (cmd.bit_mod)
        begin
            case (req_reg)
                REQ_SET:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | bit_mask;
                end
                REQ_CLEAR:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~bit_mask;
                end
                default:
                    hit_next = ram_rdata[pos_reg[OFF_W-1:0]];
            endcase
        end

        if (cmd.scan)
        begin
            if (word_hit)
            begin
                hit_next   = in_lim;
                found_next = in_lim ? idx[POS_W-1:0] : '0;
                wdata_next = ram_rdata | low_bit;
            end
            else if (scan_done)
            begin
                hit_next = 1'b0;
            end
            if (rd_ok)
            begin
                rd_w_next = rd_w_reg + 1'b1;
            end
            chk_vld_next = rd_ok && !word_hit;
            if (!word_hit)
            begin
                chk_w_next = rd_w_reg;
            end
            if (chk_vld_reg)
            begin
                off_next = '0;
            end
        end

        if (cmd.alloc_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = chk_w_reg[AW-1:0];
            ram_wdata = wdata_reg;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
            o_hit_next    = hit_reg;
            o_found_next  = found_reg;
            o_rerr_next   = rerr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg <= NUM_BITS_RESET;
            rd_w_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                num_bits_reg <= cfg_wdata;
            end
            rd_w_reg     <= rd_w_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pos_reg     <= pos_next;
        lim_reg     <= lim_next;
        chk_w_reg   <= chk_w_next;
        off_reg     <= off_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        rerr_reg    <= rerr_next;
        wdata_reg   <= wdata_next;
        o_hit_reg   <= o_hit_next;
        o_found_reg <= o_found_next;
        o_rerr_reg  <= o_rerr_next;
    end

    abe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_w_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, o_rerr_reg, o_found_reg, o_hit_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word loaded over a pending one");

    a_load_flushes_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !chk_vld_reg)
        else $error("scan pipeline not flushed on new request");

    a_found_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && o_found_reg != '0) |-> o_hit_reg)
        else $error("nonzero position reported without hit");

    a_rerr_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && o_rerr_reg) |-> (o_found_reg == '0))
        else $error("range error reported with a position");

endmodule

`default_nettype wire

// ===== hdl/allocation_bitmap_engine.sv =====
// Allocation bitmap engine: bitmap of MAX_BITS positions with set, clear,
// test, clear all, allocate and find-first searches. Depends on abe_pkg, abe_ctrl, abe_dp.
//
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser holds the request code,
//   s_tdata the bit position. Each request yields one result word on
//   m_tvalid/m_tready. cfg_wen/cfg_wdata write num_bits; the user must do
//   so only while idle, the block does not enforce it. Set, clear and test
//   pass through the read and modify states to the result; an out-of-range
//   bit operation or an unused code goes straight to the result. A search
//   or allocate reads one RAM word per cycle, full or empty words skipped,
//   bounded by num_bits; a found allocate then writes its word back. Clear all
//   writes one RAM word per cycle. NUM_WORDS = MAX_BITS / 64 rounded up.
//   One request is in work at a time; the next is accepted once the
//   result of the previous one sits in the output register.
//   After reset all NUM_WORDS RAM words (64 at the default) are swept to
//   zero with s_tready low; num_bits resets to 4096. A stalled receiver holds
//   the result word and blocks the next result, not the next accept.
`default_nettype none

module allocation_bitmap_engine
    import abe_pkg::*;
#(
    parameter int MAX_BITS = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [11:0] position
    input  wire logic [REQ_W-1:0] s_tuser,   // [2:0] req_type
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata,   // [0] hit, [12:1] found_position, [13] range_error
    input  wire logic             cfg_wen,
    input  wire logic [NB_W-1:0]  cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    abe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    abe_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_in    (s_tuser),
        .pos_in    (s_tdata[POS_W-1:0]),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
